// File: src/apps_pkg.sv
// ----------------------------------------------------------------------------
// apps_pkg
// Shared types and constants for the ASCII position parser and smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package apps_pkg;

  localparam int FIELD_CHARS_DEF = 10;
  localparam int FRAC_BITS       = 16;

  localparam int BYTE_W     = 8;
  localparam int MEAS_W     = 32;
  localparam int EST_W      = 48;
  localparam int EERR_W     = 16;
  localparam int GAIN_W     = FRAC_BITS + 1;
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int DIFF_W     = EST_W + 1;
  localparam int MAG_HI_W   = DIFF_W - FRAC_BITS;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [BYTE_W-1:0] CH_X     = 8'h58;
  localparam logic [BYTE_W-1:0] CH_Y     = 8'h59;
  localparam logic [BYTE_W-1:0] CH_C     = 8'h63;
  localparam logic [BYTE_W-1:0] CH_M     = 8'h6d;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;

  localparam logic [EERR_W-1:0] EERR_RESET = 16'd5;

  localparam logic REG_EST_ERR = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_DIST,
    ST_ABS,
    ST_DIVSET,
    ST_DIV,
    ST_MULLO,
    ST_MULHI,
    ST_SUM,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic parse;
    logic close;
    logic delta;
    logic absv;
    logic div_set;
    logic div_step;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic upd;
    logic load_out;
    logic ch;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: src/apps_in_if.sv
// ----------------------------------------------------------------------------
// apps_in_if
// Byte request channel: one received byte and its end-of-buffer flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface apps_in_if;
  logic                            valid;
  logic                            ready;
  logic [apps_pkg::BYTE_W-1:0]     rx_byte;
  logic                            buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

// File: src/apps_out_if.sv
// ----------------------------------------------------------------------------
// apps_out_if
// Result request channel: smoothed and raw position values of one buffer.
// ----------------------------------------------------------------------------
`default_nettype none

interface apps_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [apps_pkg::EST_W-1:0]   smoothed_first;
  logic signed [apps_pkg::EST_W-1:0]   smoothed_second;
  logic signed [apps_pkg::MEAS_W-1:0]  parsed_y_cm;
  logic signed [apps_pkg::MEAS_W-1:0]  parsed_x_cm;

  modport source (output valid, output smoothed_first, output smoothed_second,
                  output parsed_y_cm, output parsed_x_cm, input ready);
  modport sink   (input valid, input smoothed_first, input smoothed_second,
                  input parsed_y_cm, input parsed_x_cm, output ready);
endinterface

`default_nettype wire

// File: src/apps_cfg.sv
// ----------------------------------------------------------------------------
// apps_cfg
// APB register file holding the estimate error.
// ----------------------------------------------------------------------------
`default_nettype none

module apps_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [apps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [apps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [apps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output logic      [apps_pkg::EERR_W-1:0]       est_err
);

  logic [apps_pkg::EERR_W-1:0] est_err_r;
  logic [apps_pkg::EERR_W-1:0] est_err_nxt;
  logic                        reg_sel;

  assign reg_sel = paddr[apps_pkg::CFG_ADDR_W-1];
  assign pready  = 1'b1;
  assign est_err = est_err_r;

  always_comb begin
    est_err_nxt = est_err_r;
    if (psel && penable && pwrite && (reg_sel == apps_pkg::REG_EST_ERR)) begin
      est_err_nxt = pwdata[apps_pkg::EERR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == apps_pkg::REG_EST_ERR) begin
      prdata = {{(apps_pkg::CFG_DATA_W - apps_pkg::EERR_W){1'b0}}, est_err_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_err_r <= apps_pkg::EERR_RESET;
    end else begin
      est_err_r <= est_err_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/apps_ctrl.sv
// ----------------------------------------------------------------------------
// apps_ctrl
// Sequencer: accepts bytes, then steps both channels through the smoother.
// ----------------------------------------------------------------------------
`default_nettype none

module apps_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  output logic                 in_ready,
  input  wire apps_pkg::sts_t  sts,
  output apps_pkg::cmd_t       cmd
);

  apps_pkg::state_t              state_r, state_nxt;
  logic                          ch_r, ch_nxt;
  logic [apps_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      apps_pkg::ST_IDLE: begin
        if (in_valid && in_last) begin
          state_nxt = apps_pkg::ST_CLOSE;
        end
      end
      apps_pkg::ST_CLOSE:  state_nxt = apps_pkg::ST_DIST;
      apps_pkg::ST_DIST:   state_nxt = apps_pkg::ST_ABS;
      apps_pkg::ST_ABS:    state_nxt = apps_pkg::ST_DIVSET;
      apps_pkg::ST_DIVSET: begin
        state_nxt = apps_pkg::ST_DIV;
        cnt_nxt   = '0;
      end
      apps_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == apps_pkg::CNT_W'(apps_pkg::DIV_STEPS - 1)) begin
          state_nxt = apps_pkg::ST_MULLO;
        end
      end
      apps_pkg::ST_MULLO:  state_nxt = apps_pkg::ST_MULHI;
      apps_pkg::ST_MULHI:  state_nxt = apps_pkg::ST_SUM;
      apps_pkg::ST_SUM:    state_nxt = apps_pkg::ST_UPD;
      apps_pkg::ST_UPD: begin
        ch_nxt    = ~ch_r;
        state_nxt = ch_r ? apps_pkg::ST_OUT : apps_pkg::ST_DIST;
      end
      apps_pkg::ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = apps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = apps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.ch   = ch_r;
    in_ready = 1'b0;
    case (state_r)
      apps_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.parse = in_valid;
      end
      apps_pkg::ST_CLOSE:  cmd.close    = 1'b1;
      apps_pkg::ST_DIST:   cmd.delta    = 1'b1;
      apps_pkg::ST_ABS:    cmd.absv     = 1'b1;
      apps_pkg::ST_DIVSET: cmd.div_set  = 1'b1;
      apps_pkg::ST_DIV:    cmd.div_step = 1'b1;
      apps_pkg::ST_MULLO:  cmd.mul_lo   = 1'b1;
      apps_pkg::ST_MULHI:  cmd.mul_hi   = 1'b1;
      apps_pkg::ST_SUM:    cmd.sum      = 1'b1;
      apps_pkg::ST_UPD:    cmd.upd      = 1'b1;
      apps_pkg::ST_OUT:    cmd.load_out = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apps_pkg::ST_IDLE;
      ch_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/apps_dp.sv
// ----------------------------------------------------------------------------
// apps_dp
// Field parsers, serial gain divider, multiply and estimate update, result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module apps_dp #(
  parameter int FIELD_CHARS = apps_pkg::FIELD_CHARS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire apps_pkg::cmd_t                      cmd,
  output apps_pkg::sts_t                           sts,
  input  wire logic        [apps_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic        [apps_pkg::EERR_W-1:0]  est_err,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed      [apps_pkg::EST_W-1:0]   smoothed_first,
  output logic signed      [apps_pkg::EST_W-1:0]   smoothed_second,
  output logic signed      [apps_pkg::MEAS_W-1:0]  parsed_y_cm,
  output logic signed      [apps_pkg::MEAS_W-1:0]  parsed_x_cm
);

  localparam int STEP_W = $clog2(FIELD_CHARS + 3);
  localparam int MW     = apps_pkg::MEAS_W;
  localparam int EW     = apps_pkg::EST_W;
  localparam int DW     = apps_pkg::DIFF_W;
  localparam int FB     = apps_pkg::FRAC_BITS;
  localparam int GW     = apps_pkg::GAIN_W;
  localparam int RW     = MW + 1;
  localparam int LOP_W  = FB + GW;
  localparam int PHI_W  = apps_pkg::MAG_HI_W + GW;

  localparam logic [STEP_W-1:0] STEP_IDLE  = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_SKIP1 = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_READ  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(FIELD_CHARS + 2);

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              neg;
    logic [MW-1:0]     acc;
  } fld_t;

  // index 0: X field, index 1: Y field
  fld_t              fld_r   [2];
  fld_t              fld_nxt [2];
  logic [MW-1:0]     bufv_r  [2];
  logic [MW-1:0]     bufv_nxt[2];
  logic [MW-1:0]     acc_new [2];
  logic [15:0]       recent_r, recent_nxt;
  logic [MW-1:0]     digit;

  logic signed [EW-1:0] est_r  [2];
  logic        [MW-1:0] last_r [2];

  logic [MW:0]          dd_r;
  logic [DW-1:0]        tdiff_r;
  logic [MW-1:0]        d_r;
  logic [DW-1:0]        mag_r;
  logic                 negd_r;
  logic [RW-1:0]        div_r;
  logic [RW-1:0]        rem_r;
  logic                 bit_r;
  logic [GW-1:0]        quo_r;
  logic [LOP_W-1:0]     lop_r;
  logic [PHI_W-1:0]     phi_r;
  logic [DW-1:0]        q_r;
  logic                 remb_r;

  logic                 out_valid_r;
  logic signed [EW-1:0] out_first_r, out_second_r;
  logic [MW-1:0]        out_y_r, out_x_r;

  logic [MW-1:0]        meas;
  logic [RW:0]          shifted;
  logic [RW+1:0]        trial;
  logic [GW-1:0]        gain;
  logic [DW-1:0]        addend;
  logic [DW-1:0]        est_sum;
  logic                 ch;

  assign ch    = cmd.ch;
  assign digit = {{(MW - apps_pkg::BYTE_W){1'b0}}, rx_byte} - MW'(apps_pkg::CH_ZERO);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      fld_nxt[i]  = fld_r[i];
      bufv_nxt[i] = bufv_r[i];
      if (fld_r[i].neg) begin
        acc_new[i] = (fld_r[i].acc << 3) + (fld_r[i].acc << 1) - digit;
      end else begin
        acc_new[i] = (fld_r[i].acc << 3) + (fld_r[i].acc << 1) + digit;
      end
      if (fld_r[i].step == STEP_READ && rx_byte == apps_pkg::CH_MINUS) begin
        acc_new[i] = fld_r[i].acc;
      end
      if (cmd.parse) begin
        if (fld_r[i].step == STEP_IDLE) begin
          fld_nxt[i] = fld_r[i];
        end else if (fld_r[i].step < STEP_READ) begin
          fld_nxt[i].step = fld_r[i].step + 1'b1;
        end else if (rx_byte == apps_pkg::CH_COMMA) begin
          bufv_nxt[i] = fld_r[i].acc;
          fld_nxt[i]  = '0;
        end else begin
          if (fld_r[i].step == STEP_READ && rx_byte == apps_pkg::CH_MINUS) begin
            fld_nxt[i].neg = 1'b1;
          end
          fld_nxt[i].acc = acc_new[i];
          if (fld_r[i].step >= STEP_LAST) begin
            bufv_nxt[i] = acc_new[i];
            fld_nxt[i]  = '0;
          end else begin
            fld_nxt[i].step = fld_r[i].step + 1'b1;
          end
        end
        if (rx_byte == apps_pkg::CH_M &&
            recent_r == {((i == 0) ? apps_pkg::CH_X : apps_pkg::CH_Y), apps_pkg::CH_C}) begin
          fld_nxt[i].step = STEP_SKIP1;
          fld_nxt[i].neg  = 1'b0;
          fld_nxt[i].acc  = '0;
        end
      end
      if (cmd.close && fld_r[i].step != STEP_IDLE) begin
        bufv_nxt[i] = fld_r[i].acc;
        fld_nxt[i]  = '0;
      end
      if (cmd.load_out) begin
        bufv_nxt[i] = '0;
      end
    end
  end

  always_comb begin
    recent_nxt = recent_r;
    if (cmd.parse) begin
      recent_nxt = {recent_r[7:0], rx_byte};
    end else if (cmd.close) begin
      recent_nxt = '0;
    end
  end

  assign meas    = ch ? bufv_r[0] : bufv_r[1];
  assign shifted = {rem_r, bit_r};
  assign trial   = {1'b0, shifted} - {2'b00, div_r};
  assign gain    = (est_err == '0) ? '0 : quo_r;
  assign addend  = negd_r ? ~q_r : q_r;
  assign est_sum = {est_r[ch][EW-1], est_r[ch]} + addend +
                   DW'(negd_r && !remb_r);

  always_ff @(posedge clk) begin
    if (cmd.delta) begin
      dd_r    <= {last_r[ch][MW-1], last_r[ch]} - {meas[MW-1], meas};
      tdiff_r <= {meas[MW-1], meas, {FB{1'b0}}} - {est_r[ch][EW-1], est_r[ch]};
    end
    if (cmd.absv) begin
      d_r    <= dd_r[MW] ? MW'(-dd_r) : dd_r[MW-1:0];
      mag_r  <= tdiff_r[DW-1] ? -tdiff_r : tdiff_r;
      negd_r <= tdiff_r[DW-1];
    end
    if (cmd.div_set) begin
      div_r <= RW'(est_err) + RW'(d_r);
      rem_r <= RW'(est_err >> 1);
      bit_r <= est_err[0];
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      bit_r <= 1'b0;
      quo_r <= {quo_r[GW-2:0], !trial[RW+1]};
      if (!trial[RW+1]) begin
        rem_r <= trial[RW-1:0];
      end else begin
        rem_r <= shifted[RW-1:0];
      end
    end
    if (cmd.mul_lo) begin
      lop_r <= LOP_W'(mag_r[FB-1:0]) * LOP_W'(gain);
    end
    if (cmd.mul_hi) begin
      phi_r <= PHI_W'(mag_r[DW-1:FB]) * PHI_W'(gain);
    end
    if (cmd.sum) begin
      q_r    <= phi_r[DW-1:0] + DW'(lop_r[LOP_W-1:FB]);
      remb_r <= (lop_r[FB-1:0] != '0);
    end
    if (cmd.load_out) begin
      out_first_r  <= est_r[0];
      out_second_r <= est_r[1];
      out_y_r      <= bufv_r[1];
      out_x_r      <= bufv_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        fld_r[i]  <= '0;
        bufv_r[i] <= '0;
        est_r[i]  <= '0;
        last_r[i] <= '0;
      end
      recent_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < 2; i++) begin
        fld_r[i]  <= fld_nxt[i];
        bufv_r[i] <= bufv_nxt[i];
      end
      recent_r <= recent_nxt;
      if (cmd.upd) begin
        est_r[ch]  <= est_sum[EW-1:0];
        last_r[ch] <= meas;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign smoothed_first  = out_first_r;
  assign smoothed_second = out_second_r;
  assign parsed_y_cm     = out_y_r;
  assign parsed_x_cm     = out_x_r;

endmodule

`default_nettype wire

// File: src/ascii_position_parser_smoother_unit.sv
// ----------------------------------------------------------------------------
// ascii_position_parser_smoother_unit
// Parses Xcm/Ycm decimal fields from UART buffers and smooths both values.
// ----------------------------------------------------------------------------
// Bytes of a buffer arrive on in_ch, one per request, the last flagged by
// buffer_end. An ordinary byte is accepted whenever the sequencer is idle.
// The last byte starts the smoother: it closes open fields, then steps each
// channel in turn through difference, magnitude, divider setup, the
// steps of the shared radix-2 gain divider, two partial-product multiplies,
// sum and update, then loads the result register for out_ch. The result
// register lets the next buffer's bytes flow in while a result waits; a
// second result waits in the sequencer until the first is taken. The user
// must write the estimate error over the APB port (addresses 0 to 3, paddr[2]
// clear) only while the block is idle; the block does not enforce this.
`default_nettype none

module ascii_position_parser_smoother_unit #(
  parameter int FIELD_CHARS = apps_pkg::FIELD_CHARS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  apps_in_if.sink                                in_ch,
  apps_out_if.source                             out_ch,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [apps_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [apps_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [apps_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);

  apps_pkg::cmd_t                  cmd;
  apps_pkg::sts_t                  sts;
  logic [apps_pkg::EERR_W-1:0]     est_err;
  logic                            in_ready;

  apps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .est_err (est_err)
  );

  apps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.buffer_end),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  apps_dp #(
    .FIELD_CHARS (FIELD_CHARS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .rx_byte         (in_ch.rx_byte),
    .est_err         (est_err),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .smoothed_first  (out_ch.smoothed_first),
    .smoothed_second (out_ch.smoothed_second),
    .parsed_y_cm     (out_ch.parsed_y_cm),
    .parsed_x_cm     (out_ch.parsed_x_cm)
  );

endmodule

`default_nettype wire
